// ----- rtl/radio_time_code_pulse_sampler_defines.svh -----
// Assertion macros used by the pulse sampler control block, rtcps_ctrl.
// Each macro expects signals named clk and rst in the scope that uses it.
`ifndef RADIO_TIME_CODE_PULSE_SAMPLER_DEFINES_SVH
`define RADIO_TIME_CODE_PULSE_SAMPLER_DEFINES_SVH

// Check a consequence in the same cycle as its trigger.
`define RTCPS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rtcps assertion failed");

// Check a consequence in the cycle after its trigger.
`define RTCPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rtcps assertion failed");

`endif

// ----- rtl/rtcps_pkg.sv -----
// Types, codes and reset constants for the radio time-code pulse sampler.
// No dependencies; used by rtcps_ctrl and the top level of the block.
`default_nettype none

package rtcps_pkg;

  // Item operations
  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_ACQUIRE = 2'd1,
    OP_RELEASE = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_NOISE_REJECT = 2'd0;
  localparam logic [1:0] CFG_HALF_SECOND  = 2'd1;
  localparam logic [1:0] CFG_MATCH_TOL    = 2'd2;

  // Configuration reset values
  localparam logic [7:0] NOISE_REJECT_RESET = 8'd5;
  localparam logic [7:0] HALF_SECOND_RESET  = 8'd50;
  localparam logic [7:0] MATCH_TOL_RESET    = 8'd10;

  // Marker search state machine
  typedef enum logic [5:0] {
    MODE_IDLE      = 6'b000001,
    MODE_START     = 6'b000010,
    MODE_WAIT_LOW  = 6'b000100,
    MODE_MARK_LOW  = 6'b001000,
    MODE_MARK_HIGH = 6'b010000,
    MODE_SAMPLING  = 6'b100000
  } mode_t;

  // Mode codes as seen on the result
  localparam logic [2:0] MODE_CODE_IDLE      = 3'd0;
  localparam logic [2:0] MODE_CODE_START     = 3'd1;
  localparam logic [2:0] MODE_CODE_WAIT_LOW  = 3'd2;
  localparam logic [2:0] MODE_CODE_MARK_LOW  = 3'd3;
  localparam logic [2:0] MODE_CODE_MARK_HIGH = 3'd4;
  localparam logic [2:0] MODE_CODE_SAMPLING  = 3'd5;

  // Buffer owner
  typedef enum logic [1:0] {
    OWN_NOBODY  = 2'd0,
    OWN_SAMPLER = 2'd1,
    OWN_CLIENT  = 2'd2
  } owner_t;

  // Input beat
  typedef struct packed {
    op_t        op;
    logic       level;
    logic [7:0] read_index;
  } rtcps_in_t;

  // Result beat
  typedef struct packed {
    logic        granted;
    logic [7:0]  read_data;
    logic [8:0]  entry_count;
    logic [31:0] minute_start_time;
    logic [31:0] tick_now;
    logic [2:0]  mode;
    logic [1:0]  holder;
  } rtcps_out_t;

  // Status of one processed item, handed from control to the output register
  typedef struct packed {
    logic        granted;
    logic        rd_hit;
    logic [8:0]  entry_count;
    logic [31:0] start_time;
    logic [31:0] tick_now;
    logic [2:0]  mode;
    owner_t      holder;
  } rtcps_status_t;

  // Encode the one-hot mode as its result code
  function automatic logic [2:0] mode_code(mode_t m);
    logic [2:0] code;
    unique case (m)
      MODE_IDLE:      code = MODE_CODE_IDLE;
      MODE_START:     code = MODE_CODE_START;
      MODE_WAIT_LOW:  code = MODE_CODE_WAIT_LOW;
      MODE_MARK_LOW:  code = MODE_CODE_MARK_LOW;
      MODE_MARK_HIGH: code = MODE_CODE_MARK_HIGH;
      MODE_SAMPLING:  code = MODE_CODE_SAMPLING;
      default:        code = MODE_CODE_START;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/rtcps_buf.sv -----
// Period buffer: one write port and one registered read port.
// Standalone; instantiated by the top level.
`default_nettype none

module rtcps_buf #(
  parameter int BUFFER_DEPTH = 256,
  localparam int AW = $clog2(BUFFER_DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data
);

  logic [7:0] mem [BUFFER_DEPTH];

  // Store one period
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read and hold until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rtcps_ctrl.sv -----
// Edge tracking, marker search, buffer ownership and configuration registers.
// Depends on rtcps_pkg and radio_time_code_pulse_sampler_defines.svh.
`default_nettype none

`include "radio_time_code_pulse_sampler_defines.svh"

module rtcps_ctrl #(
  parameter int BUFFER_DEPTH = 256,
  localparam int AW = $clog2(BUFFER_DEPTH)
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   take,
  input  wire rtcps_pkg::rtcps_in_t   item,
  input  wire logic                   cfg_write,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [7:0]             cfg_data,
  output rtcps_pkg::rtcps_status_t    status_next,
  output logic                        wr_en,
  output logic [AW-1:0]               wr_addr,
  output logic [7:0]                  wr_data,
  output logic                        rd_en,
  output logic [AW-1:0]               rd_addr
);

  import rtcps_pkg::*;

  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam int IW = (CW > 8) ? CW : 8;

  // Configuration
  logic [7:0] noise_reject;
  logic [7:0] half_second;
  logic [7:0] match_tol;

  // Sampler state
  mode_t       mode, mode_next;
  owner_t      owner, owner_next;
  logic [31:0] tick, tick_next;
  logic        last_level, last_level_next;
  logic [31:0] dist_rise, dist_rise_next;
  logic [31:0] dist_fall, dist_fall_next;
  logic [31:0] fall_time, fall_time_next;
  logic [31:0] start_time, start_time_next;
  logic [CW-1:0] fill, fill_next;

  // Per-tick terms
  logic        lvl;
  logic [31:0] period;
  logic        long_pulse;
  logic        level_change;
  logic        rise_edge;
  logic        fall_edge;
  logic        glitch;
  logic [7:0]  match_lo;
  logic [8:0]  match_hi;
  logic        is_match;
  logic        room;
  logic        keep;
  logic        store;
  logic        granted;
  logic        rd_hit;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      noise_reject <= NOISE_REJECT_RESET;
      half_second  <= HALF_SECOND_RESET;
      match_tol    <= MATCH_TOL_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_NOISE_REJECT: noise_reject <= cfg_data;
        CFG_HALF_SECOND:  half_second  <= cfg_data;
        CFG_MATCH_TOL:    match_tol    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pulse length on this tick's edge and its classification
  always_comb begin
    lvl          = item.level;
    period       = lvl ? dist_fall : dist_rise;
    long_pulse   = period > 32'(noise_reject);
    level_change = lvl != last_level;
    rise_edge    = level_change && long_pulse && lvl;
    fall_edge    = level_change && long_pulse && !lvl;
    glitch       = level_change && !long_pulse;
    match_lo     = (half_second > match_tol) ? (half_second - match_tol) : 8'd0;
    match_hi     = {1'b0, half_second} + {1'b0, match_tol};
    is_match     = (period >= 32'(match_lo)) && (period <= 32'(match_hi));
    room         = fill != CW'(BUFFER_DEPTH);
  end

  // Next state for the item at the input
  always_comb begin
    mode_next       = mode;
    owner_next      = owner;
    tick_next       = tick;
    last_level_next = last_level;
    dist_rise_next  = dist_rise;
    dist_fall_next  = dist_fall;
    fall_time_next  = fall_time;
    start_time_next = start_time;
    fill_next       = fill;
    keep            = 1'b0;
    store           = 1'b0;
    granted         = 1'b0;
    rd_hit          = 1'b0;

    unique case (item.op)
      OP_TICK: begin
        tick_next       = tick + 32'd1;
        last_level_next = lvl;
        dist_rise_next  = rise_edge ? 32'd1 : dist_rise + 32'd1;
        dist_fall_next  = fall_edge ? 32'd1 : dist_fall + 32'd1;
        if (fall_edge) begin
          fall_time_next = tick + 32'd1;
        end
        // Drop the last stored period on a glitch while sampling
        if (glitch && mode == MODE_SAMPLING && fill != '0) begin
          fill_next = fill - CW'(1);
        end

        unique case (mode)
          MODE_IDLE: ;
          MODE_START, MODE_WAIT_LOW: begin
            if (fall_edge) begin
              mode_next = MODE_MARK_LOW;
            end
          end
          MODE_MARK_LOW: begin
            if (rise_edge) begin
              mode_next = is_match ? MODE_MARK_HIGH : MODE_WAIT_LOW;
            end
          end
          MODE_MARK_HIGH: begin
            if (fall_edge) begin
              if (is_match) begin
                if (owner == OWN_SAMPLER || owner == OWN_NOBODY) begin
                  owner_next = OWN_SAMPLER;
                  fill_next  = '0;
                  mode_next  = MODE_SAMPLING;
                end else begin
                  mode_next = MODE_START;
                end
              end else begin
                mode_next = MODE_MARK_LOW;
              end
            end
          end
          MODE_SAMPLING: begin
            if (fall_edge) begin
              keep = owner == OWN_SAMPLER;
            end else if (rise_edge) begin
              if (is_match) begin
                // Closing marker: publish its start and free the buffer
                if (owner == OWN_SAMPLER) begin
                  start_time_next = fall_time;
                  owner_next      = OWN_NOBODY;
                end
                mode_next = MODE_MARK_HIGH;
              end else begin
                keep = owner == OWN_SAMPLER;
              end
            end
          end
          default: mode_next = MODE_START;
        endcase

        // Store the pulse, or give up the buffer when it is full
        if (keep) begin
          if (room) begin
            store     = 1'b1;
            fill_next = fill + CW'(1);
            mode_next = MODE_SAMPLING;
          end else begin
            owner_next = OWN_NOBODY;
            mode_next  = MODE_START;
          end
        end
      end
      OP_ACQUIRE: begin
        if (owner == OWN_NOBODY && fill != '0) begin
          owner_next = OWN_CLIENT;
          granted    = 1'b1;
        end else if (owner == OWN_CLIENT) begin
          fill_next  = '0;
          owner_next = OWN_NOBODY;
        end
      end
      OP_RELEASE: begin
        fill_next  = '0;
        owner_next = OWN_NOBODY;
      end
      OP_READ: begin
        rd_hit = (IW'(item.read_index) < IW'(fill)) &&
                 (IW'(item.read_index) < IW'(BUFFER_DEPTH));
      end
      default: ;
    endcase
  end

  // Buffer access
  assign wr_en   = take && store;
  assign wr_addr = fill[AW-1:0];
  assign wr_data = (|period[31:8]) ? 8'hFF : period[7:0];
  assign rd_en   = take && item.op == OP_READ;
  assign rd_addr = AW'(item.read_index);

  // Status after this item
  always_comb begin
    status_next.granted     = granted;
    status_next.rd_hit      = rd_hit;
    status_next.entry_count = 9'(fill_next);
    status_next.start_time  = start_time_next;
    status_next.tick_now    = tick_next;
    status_next.mode        = mode_code(mode_next);
    status_next.holder      = owner_next;
  end

  // Advance state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_START;
      owner      <= OWN_NOBODY;
      tick       <= '0;
      last_level <= 1'b1;
      dist_rise  <= 32'd1;
      dist_fall  <= 32'd1;
      fall_time  <= '0;
      start_time <= '0;
      fill       <= '0;
    end else if (take) begin
      mode       <= mode_next;
      owner      <= owner_next;
      tick       <= tick_next;
      last_level <= last_level_next;
      dist_rise  <= dist_rise_next;
      dist_fall  <= dist_fall_next;
      fall_time  <= fall_time_next;
      start_time <= start_time_next;
      fill       <= fill_next;
    end
  end

  `RTCPS_ASSERT_SAME(a_fill_in_range, 1'b1, fill <= CW'(BUFFER_DEPTH))
  `RTCPS_ASSERT_NEXT(a_client_keeps_tick, take && item.op != OP_TICK, $stable(tick))
  `RTCPS_ASSERT_SAME(a_store_by_sampler, wr_en, owner == OWN_SAMPLER && mode == MODE_SAMPLING)
  `RTCPS_ASSERT_SAME(a_sampler_only_sampling, owner == OWN_SAMPLER, mode == MODE_SAMPLING)

endmodule

`default_nettype wire

// ----- rtl/radio_time_code_pulse_sampler.sv -----
// Radio time-code pulse sampler: top level with the output register.
// Depends on rtcps_pkg, rtcps_ctrl and rtcps_buf.
`default_nettype none

// Takes one beat per clock while in_ready is high and returns exactly one result
// beat per input beat, in the cycle after it is accepted. Tick beats advance the
// tick counter and feed the carrier level to the marker search; acquire,
// release and read beats act on the period buffer. The state update, the
// buffer write and the buffer read all happen at the edge that accepts the
// beat; the registered read data and the item status meet in the output register.
// in_ready is low only while that register holds a result that out_ready has
// not taken, so the block sustains one item per cycle while out_ready is high.
// The buffer needs no clearing pass after reset: entries at or beyond the fill
// count read as zero. Configuration writes are taken in every cycle.
module radio_time_code_pulse_sampler #(
  parameter int BUFFER_DEPTH = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire rtcps_pkg::rtcps_in_t  in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output rtcps_pkg::rtcps_out_t      out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [7:0]            cfg_data
);

  import rtcps_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);

  logic           take;
  rtcps_status_t  status_next;
  rtcps_status_t  status;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [7:0]     wr_data;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic [7:0]     rd_data;

  // Accept whenever the output register is free or being drained
  assign in_ready  = !out_valid || out_ready;
  assign take      = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  rtcps_ctrl #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .item       (in_data),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .status_next(status_next),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr)
  );

  rtcps_buf #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_buf (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Output valid: set on accept, clear when the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Hold the item status until the next accept
  always_ff @(posedge clk) begin
    if (take) begin
      status <= status_next;
    end
  end

  // Assemble the result beat
  always_comb begin
    out_data.granted           = status.granted;
    out_data.read_data         = status.rd_hit ? rd_data : 8'd0;
    out_data.entry_count       = status.entry_count;
    out_data.minute_start_time = status.start_time;
    out_data.tick_now          = status.tick_now;
    out_data.mode              = status.mode;
    out_data.holder            = status.holder;
  end

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking bench for radio_time_code_pulse_sampler: drives tick and client beats,
// predicts each result beat in a local copy of the block, compares it field by field.
// Depends on rtcps_pkg and the RTL of the block; reads no files.
`default_nettype none

module tb;
  import rtcps_pkg::*;

  localparam int DEPTH        = 256;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 150;

  typedef enum logic [1:0] {NO_MOVE, ROSE, FELL} level_move_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  rtcps_in_t  in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  rtcps_out_t out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data  = '0;

  // Predicted block state and configuration
  logic [7:0]  glitch_limit, half_ticks, tolerance;
  logic [2:0]  mode_q;
  logic [31:0] tick_q, rise_at, fall_at, marker_at, minute_at;
  logic        level_q;
  owner_t      owner_q;
  logic [7:0]  periods [DEPTH];
  logic [8:0]  fill_q;

  rtcps_out_t pending_results [$];
  int         fail_count  = 0;
  int         items_sent  = 0;
  int         beats_seen  = 0;
  int         cycle_count = 0;
  int         stall_left  = 0;
  int         client_mix  = 0;
  bit         steady      = 1'b0;

  radio_time_code_pulse_sampler #(.BUFFER_DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  task automatic reset_state();
    glitch_limit = NOISE_REJECT_RESET;
    half_ticks   = HALF_SECOND_RESET;
    tolerance    = MATCH_TOL_RESET;
    mode_q       = MODE_CODE_START;
    tick_q       = '0;
    level_q      = 1'b1;
    rise_at      = '0;
    fall_at      = '0;
    marker_at    = '0;
    minute_at    = '0;
    owner_q      = OWN_NOBODY;
    fill_q       = '0;
    foreach (periods[i]) periods[i] = '0;
  endtask

  function automatic bit near_half(logic [31:0] p);
    logic [31:0] d;
    d = (p >= half_ticks) ? p - half_ticks : half_ticks - p;
    return d <= tolerance;
  endfunction

  // Append one pulse length, or give up the buffer when it is full
  function automatic void store_period(logic [31:0] p);
    if (fill_q < DEPTH) begin
      periods[fill_q[7:0]] = (p > 255) ? 8'd255 : p[7:0];
      fill_q = fill_q + 1'b1;
      mode_q = MODE_CODE_SAMPLING;
    end else begin
      owner_q = OWN_NOBODY;
      mode_q  = MODE_CODE_START;
    end
  endfunction

  function automatic void advance_tick(logic lvl);
    level_move_t move;
    logic [31:0] p;
    move   = NO_MOVE;
    p      = '0;
    tick_q = tick_q + 1;
    // Classify the edge; a short one is a glitch and, while sampling, undoes the last entry
    if (lvl != level_q) begin
      p = tick_q - (lvl ? fall_at : rise_at);
      if (p > glitch_limit) begin
        if (lvl) begin
          rise_at = tick_q;
          move    = ROSE;
        end else begin
          fall_at = tick_q;
          move    = FELL;
        end
      end else if (mode_q == MODE_CODE_SAMPLING && fill_q != 0) begin
        fill_q = fill_q - 1'b1;
      end
    end
    // Advance the marker search
    case (mode_q)
      MODE_CODE_IDLE: ;
      MODE_CODE_START, MODE_CODE_WAIT_LOW: begin
        if (move == FELL) begin
          marker_at = tick_q;
          mode_q    = MODE_CODE_MARK_LOW;
        end
      end
      MODE_CODE_MARK_LOW: begin
        if (move == ROSE) mode_q = near_half(p) ? MODE_CODE_MARK_HIGH : MODE_CODE_WAIT_LOW;
      end
      MODE_CODE_MARK_HIGH: begin
        if (move == FELL) begin
          if (near_half(p)) begin
            if (owner_q != OWN_CLIENT) begin
              owner_q = OWN_SAMPLER;
              fill_q  = '0;
              mode_q  = MODE_CODE_SAMPLING;
            end else begin
              mode_q = MODE_CODE_START;
            end
          end else begin
            marker_at = tick_q;
            mode_q    = MODE_CODE_MARK_LOW;
          end
        end
      end
      MODE_CODE_SAMPLING: begin
        if (move == FELL) begin
          if (owner_q == OWN_SAMPLER) store_period(p);
        end else if (move == ROSE) begin
          if (near_half(p)) begin
            marker_at = fall_at;
            if (owner_q == OWN_SAMPLER) begin
              minute_at = marker_at;
              owner_q   = OWN_NOBODY;
            end
            mode_q = MODE_CODE_MARK_HIGH;
          end else if (owner_q == OWN_SAMPLER) begin
            store_period(p);
          end
        end
      end
      default: mode_q = MODE_CODE_START;
    endcase
    level_q = lvl;
  endfunction

  function automatic rtcps_out_t predict_result(rtcps_in_t item);
    rtcps_out_t res;
    res = '0;
    case (item.op)
      OP_TICK: advance_tick(item.level);
      OP_ACQUIRE: begin
        if (owner_q == OWN_NOBODY && fill_q != 0) begin
          owner_q     = OWN_CLIENT;
          res.granted = 1'b1;
        end else if (owner_q == OWN_CLIENT) begin
          fill_q  = '0;
          owner_q = OWN_NOBODY;
        end
      end
      OP_RELEASE: begin
        fill_q  = '0;
        owner_q = OWN_NOBODY;
      end
      OP_READ: begin
        if (item.read_index < fill_q) res.read_data = periods[item.read_index];
      end
      default: ;
    endcase
    res.entry_count       = fill_q;
    res.minute_start_time = minute_at;
    res.tick_now          = tick_q;
    res.mode              = mode_q;
    res.holder            = owner_q;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  function automatic void report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    fail_count++;
    if (fail_count <= 10)
      $display("beat %0d %s: expected %0d, got %0d", beats_seen, what, want, got);
  endfunction

  always @(posedge clk) begin : check_results
    rtcps_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("beat %0d arrived with nothing expected", beats_seen);
      end else begin
        want = pending_results.pop_front();
        if (out_data.granted !== want.granted)
          report_mismatch("granted", 32'(want.granted), 32'(out_data.granted));
        if (out_data.read_data !== want.read_data)
          report_mismatch("read_data", 32'(want.read_data), 32'(out_data.read_data));
        if (out_data.entry_count !== want.entry_count)
          report_mismatch("entry_count", 32'(want.entry_count), 32'(out_data.entry_count));
        if (out_data.minute_start_time !== want.minute_start_time)
          report_mismatch("minute_start_time", want.minute_start_time,
                          out_data.minute_start_time);
        if (out_data.tick_now !== want.tick_now)
          report_mismatch("tick_now", want.tick_now, out_data.tick_now);
        if (out_data.mode !== want.mode)
          report_mismatch("mode", 32'(want.mode), 32'(out_data.mode));
        if (out_data.holder !== want.holder)
          report_mismatch("holder", 32'(want.holder), 32'(out_data.holder));
      end
      beats_seen++;
    end
  end

  // Stall the result side: mostly short stalls, a few long ones
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!steady && $urandom_range(99) < 20) begin
      out_ready  <= 1'b0;
      stall_left <= ($urandom_range(99) < 85) ? $urandom_range(2) : $urandom_range(30, 8);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (steady || r < 65) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(24, 6);
  endfunction

  function automatic rtcps_in_t make_item(op_t op, logic lvl, logic [7:0] idx);
    rtcps_in_t item;
    item.op         = op;
    item.level      = lvl;
    item.read_index = idx;
    return item;
  endfunction

  // Present one beat, hold it until taken, then predict its result
  task automatic send_item(rtcps_in_t item);
    int gap;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_result(item));
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic client_op();
    rtcps_in_t item;
    int r;
    r               = $urandom_range(99);
    item.level      = 1'($urandom_range(1));
    item.read_index = (fill_q != 0 && $urandom_range(3) != 0) ?
                      8'($urandom_range(fill_q - 1)) : 8'($urandom_range(255));
    if (r < 30)      item.op = OP_ACQUIRE;
    else if (r < 40) item.op = OP_RELEASE;
    else             item.op = OP_READ;
    send_item(item);
  endtask

  // Hold the carrier at one level for n ticks, with client beats mixed in
  task automatic hold_level(logic lvl, int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < client_mix) client_op();
      send_item(make_item(OP_TICK, lvl, 8'($urandom_range(255))));
    end
  endtask

  // Drop valid and wait until every result has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic put_reg(logic [1:0] idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_NOISE_REJECT: glitch_limit = val;
      CFG_HALF_SECOND:  half_ticks   = val;
      CFG_MATCH_TOL:    tolerance    = val;
      default: ;
    endcase
  endtask

  task automatic set_config(logic [7:0] noise, logic [7:0] half, logic [7:0] tol);
    drain();
    put_reg(CFG_NOISE_REJECT, noise);
    put_reg(CFG_HALF_SECOND, half);
    put_reg(CFG_MATCH_TOL, tol);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Client beats against an empty buffer
  task automatic test_empty_buffer();
    send_item(make_item(OP_ACQUIRE, 1'b0, 8'h00));
    send_item(make_item(OP_READ, 1'b1, 8'h00));
    send_item(make_item(OP_READ, 1'b0, 8'hFF));
    send_item(make_item(OP_RELEASE, 1'b1, 8'hAA));
    send_item(make_item(OP_TICK, 1'b1, 8'h55));
    send_item(make_item(OP_READ, 1'b0, 8'h55));
    send_item(make_item(OP_ACQUIRE, 1'b1, 8'hFF));
  endtask

  // Marker search, capture of one minute and the client handover
  task automatic test_minute_capture();
    set_config(8'd2, 8'd12, 8'd2);
    hold_level(1'b1, 4);
    // low half too short, then high half off by too much
    hold_level(1'b0, 6);
    hold_level(1'b1, 4);
    hold_level(1'b0, 12);
    hold_level(1'b1, 7);
    // matching marker takes the buffer
    hold_level(1'b0, 13);
    hold_level(1'b1, 11);
    hold_level(1'b0, 2);
    // glitch with an empty buffer, then real pulses
    hold_level(1'b1, 1);
    hold_level(1'b0, 5);
    hold_level(1'b1, 8);
    hold_level(1'b0, 3);
    hold_level(1'b1, 1);
    hold_level(1'b0, 5);
    hold_level(1'b1, 7);
    // over-long low pulse saturates
    hold_level(1'b0, 260);
    hold_level(1'b1, 5);
    send_item(make_item(OP_ACQUIRE, 1'b0, 8'h00));
    send_item(make_item(OP_READ, 1'b0, 8'h00));
    send_item(make_item(OP_READ, 1'b0, 8'(fill_q - 1'b1)));
    send_item(make_item(OP_READ, 1'b0, fill_q[7:0]));
    // closing marker frees the buffer for the client
    hold_level(1'b0, 12);
    hold_level(1'b1, 1);
    send_item(make_item(OP_ACQUIRE, 1'b0, 8'h00));
    send_item(make_item(OP_READ, 1'b0, 8'h01));
    hold_level(1'b1, 12);
    hold_level(1'b0, 2);
    send_item(make_item(OP_ACQUIRE, 1'b0, 8'h00));
    send_item(make_item(OP_ACQUIRE, 1'b0, 8'h00));
    send_item(make_item(OP_RELEASE, 1'b0, 8'h00));
  endtask

  // One-tick pulses fill the buffer until the sampler gives up
  task automatic test_buffer_full();
    set_config(8'd0, 8'd4, 8'd0);
    hold_level(1'b1, 6);
    hold_level(1'b0, 4);
    hold_level(1'b1, 4);
    hold_level(1'b0, 1);
    steady = 1'b1;
    for (int k = 0; k < 260; k++) hold_level(k[0] ? 1'b0 : 1'b1, 1);
    steady = 1'b0;
    send_item(make_item(OP_READ, 1'b1, 8'hFF));
    send_item(make_item(OP_READ, 1'b0, 8'h00));
    send_item(make_item(OP_READ, 1'b1, 8'h80));
    send_item(make_item(OP_ACQUIRE, 1'b0, 8'h00));
    send_item(make_item(OP_RELEASE, 1'b0, 8'h00));
  endtask

  // Extremes of every register
  task automatic test_config_extremes();
    set_config(8'd255, 8'd1, 8'd0);
    hold_level(1'b1, 3);
    hold_level(1'b0, 2);
    hold_level(1'b1, 2);
    hold_level(1'b0, 6);
    hold_level(1'b1, 4);
    hold_level(1'b0, 3);
    set_config(8'd0, 8'd255, 8'd0);
    hold_level(1'b1, 3);
    hold_level(1'b0, 12);
    hold_level(1'b1, 12);
    hold_level(1'b0, 8);
    hold_level(1'b1, 6);
    set_config(8'd0, 8'd1, 8'd255);
    client_mix = 15;
    for (int k = 0; k < 30; k++) hold_level(1'($urandom_range(1)), $urandom_range(3, 1));
    client_mix = 0;
  endtask

  function automatic int marker_half();
    int jit;
    if ($urandom_range(4) == 0) jit = tolerance + $urandom_range(3, 1);
    else                        jit = $urandom_range(tolerance);
    if ($urandom_range(1) == 0) jit = -jit;
    return (half_ticks + jit < 1) ? 1 : half_ticks + jit;
  endfunction

  function automatic int pulse_len();
    int r;
    r = $urandom_range(99);
    if (r < 2)  return $urandom_range(300, 256);
    if (r < 15) return $urandom_range(glitch_limit + 1, 1);
    return $urandom_range(glitch_limit + 1 + half_ticks / 2, glitch_limit + 1);
  endfunction

  // Mostly well-formed minutes with random content, plus noise and client bursts
  task automatic test_random_minutes();
    int start;
    int r;
    start      = items_sent;
    client_mix = 8;
    for (int phase = 0; phase < 2; phase++) begin
      set_config(8'($urandom_range(3)), 8'($urandom_range(16, 6)), 8'($urandom_range(3)));
      while (items_sent - start < (phase + 1) * RANDOM_ITEMS / 2) begin
        steady = ($urandom_range(7) == 0);
        r      = $urandom_range(99);
        if (r < 70) begin
          hold_level(1'b1, pulse_len());
          hold_level(1'b0, marker_half());
          hold_level(1'b1, marker_half());
          repeat ($urandom_range(6, 2)) begin
            hold_level(1'b0, pulse_len());
            hold_level(1'b1, pulse_len());
          end
          hold_level(1'b0, marker_half());
        end else if (r < 85) begin
          repeat ($urandom_range(6, 1)) begin
            hold_level(1'($urandom_range(1)), $urandom_range(8, 1));
          end
        end else begin
          repeat ($urandom_range(4, 1)) client_op();
        end
      end
    end
    steady     = 1'b0;
    client_mix = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence and end of run
  // ---------------------------------------------------------------------------

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    reset_state();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_empty_buffer();
    test_minute_capture();
    test_buffer_full();
    test_config_extremes();
    test_random_minutes();
    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+rtl
rtl/rtcps_pkg.sv
rtl/rtcps_buf.sv
rtl/rtcps_ctrl.sv
rtl/radio_time_code_pulse_sampler.sv
bench/tb.sv
